/* design/sha256_byte_stream_hasher_unit_defines.svh */
// Assertion helpers for the SHA-256 byte stream hasher.
// Both expect clk and rst in the scope where they are used.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SHA_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SHA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sha256bsh_pkg.sv */
package sha256bsh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Source of the byte pushed into the block register.
  typedef enum logic [1:0] {
    BSEL_INPUT,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LENGTH
  } byte_sel_t;

  typedef struct packed {
    logic      ins_byte;      // push one byte into the block register
    byte_sel_t byte_sel;
    logic      load_work;     // copy chain words into a..h, restart rounds
    logic      round_en;      // run one compression round
    logic      update_chain;  // add a..h into the chain words
    logic      emit_load;     // move the next digest word to the output register
    logic      finish;        // back to initial hash values, length to zero
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;        // bytes held in the current block
    logic       round_last;  // round 63 is running
    logic       emit_last;   // next digest word is the eighth
    logic       out_free;    // output register can take a word this cycle
  } dp_status_t;

endpackage

/* design/sha256_byte_stream_hasher_unit.sv */
// SHA-256 hasher over a byte stream.
// Input channel s_*: one transfer carries at most one message byte in
// s_tdata[7:0], qualified by s_tuser[0] (byte present); s_tlast ends the
// message after that transfer's byte, if any. A transfer with s_tlast and no
// byte is how an empty message, or a message whose bytes are all sent, closes.
// Output channel m_*: eight transfers per message, digest word 0 (most
// significant) first; m_tuser holds the word position, m_tlast marks word 7.
// The transfer that completes a 64-byte block is followed by the
// compression rounds and the chain update before s_tready returns, so no
// byte is taken while a block is compressed. On s_tlast the padding goes in
// one byte per cycle, pausing without a byte when the zero run reaches byte
// 56; each block it completes is compressed likewise. After the last
// block's chain update the digest words load into the output register one
// per cycle while m_tready stays high.
// s_tready is high only while bytes are being collected into a block.
// A stalled receiver holds the current word in the output register and
// holds the word sequencer; no word is dropped. Synchronous reset returns
// the chain words to the initial hash values and clears the length and
// byte counts.
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit import sha256bsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  // Digest word taken that is not the last, and the position that must follow it.
  logic       word_taken;
  logic [2:0] word_next_pos;

  assign word_taken    = m_tvalid && m_tready && !m_tlast;
  assign word_next_pos = m_tuser + 3'd1;

  // Sequence byte transfers, padding, rounds and digest output.
  sha256bsh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_present (s_tuser[0]),
    .in_last    (s_tlast),
    .in_ready   (s_tready),
    .status     (status),
    .cmd        (cmd),
    .state      (state)
  );

  // Block register, round logic, chain words and output register.
  sha256bsh_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_word  (m_tdata),
    .out_index (m_tuser),
    .out_last  (m_tlast)
  );

  // Padding must end exactly on a block boundary before the digest goes out.
  `SHA_CHECK_SAME(a_emit_on_boundary, state == ST_EMIT, status.fill == 6'd0, "partial block")
  // Between digest words no new message may start.
  `SHA_CHECK_SAME(a_no_input_mid_digest, m_tvalid && !m_tlast, !s_tready, "input mid digest")
  // A taken word that is not the last is followed at once by the next position.
  `SHA_CHECK_NEXT(a_word_sequence, word_taken, m_tuser == $past(word_next_pos), "word order")

endmodule

/* design/sha256bsh_datapath.sv */
module sha256bsh_datapath import sha256bsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [7:0]  data_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Block register doubles as the 16-word schedule window; word 0 sits on top.
  logic [511:0] blk;
  logic [31:0]  work [8];
  logic [31:0]  chain [8];
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  logic [5:0]   round;
  logic [2:0]   emit_idx;

  logic [31:0]  sched_w;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  ch_val;
  logic [31:0]  maj_val;
  logic [63:0]  len_shift;
  logic [7:0]   ins_val;

  always_comb begin
    if (round[5:4] == 2'b00) begin
      sched_w = blk[511:480];
    end else begin
      sched_w = blk[511:480] + small_sigma0(blk[479:448]) + blk[223:192]
              + small_sigma1(blk[63:32]);
    end
    ch_val  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj_val = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1 = work[7] + big_sigma1(work[4]) + ch_val + ROUND_K[round] + sched_w;
    t2 = big_sigma0(work[0]) + maj_val;
  end

  // Length bytes go out most significant first, fill 56..63 picks byte 0..7.
  assign len_shift = msg_bits << {fill[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      BSEL_INPUT:  ins_val = data_byte;
      BSEL_MARK:   ins_val = 8'h80;
      BSEL_ZERO:   ins_val = 8'h00;
      BSEL_LENGTH: ins_val = len_shift[63:56];
      default:     ins_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      msg_bits  <= '0;
      round     <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= HASH_INIT[i];
      end
    end else begin
      if (cmd.ins_byte) begin
        fill <= fill + 6'd1;
        if (cmd.byte_sel == BSEL_INPUT) begin
          msg_bits <= msg_bits + 64'd8;
        end
      end
      if (cmd.load_work) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 6'd1;
      end
      if (cmd.update_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end else if (cmd.finish) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= HASH_INIT[i];
        end
        msg_bits <= '0;
      end
      if (cmd.emit_load) begin
        emit_idx  <= emit_idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_byte) begin
      blk <= {blk[503:0], ins_val};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], sched_w};
    end
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
    if (cmd.emit_load) begin
      out_word  <= chain[emit_idx];
      out_index <= emit_idx;
      out_last  <= (emit_idx == 3'd7);
    end
  end

  assign status.fill       = fill;
  assign status.round_last = (round == 6'd63);
  assign status.emit_last  = (emit_idx == 3'd7);
  assign status.out_free   = !out_valid || out_ready;

endmodule

/* design/sha256bsh_ctrl.sv */
module sha256bsh_ctrl import sha256bsh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_present,
  input  logic       in_last,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output state_t     state
);

  state_t state_next;
  logic   finishing, finishing_next;
  logic   mark_done, mark_done_next;
  logic   len_done, len_done_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      mark_done <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      mark_done <= mark_done_next;
      len_done  <= len_done_next;
    end
  end

  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    mark_done_next = mark_done;
    len_done_next  = len_done;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          finishing_next = in_last;
          if (in_present && status.fill == 6'd63) begin
            state_next = ST_ROUND;
          end else if (in_last) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        mark_done_next = 1'b1;
        state_next = (status.fill == 6'd63) ? ST_ROUND : ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (status.fill == 6'd56) begin
          state_next = ST_PAD_LEN;
        end else if (status.fill == 6'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_PAD_LEN: begin
        if (status.fill == 6'd63) begin
          len_done_next = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (status.round_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (!mark_done) begin
          state_next = ST_PAD_MARK;
        end else if (!len_done) begin
          state_next = ST_PAD_ZERO;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          finishing_next = 1'b0;
          mark_done_next = 1'b0;
          len_done_next  = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.byte_sel = BSEL_INPUT;
        if (accept && in_present) begin
          cmd.ins_byte  = 1'b1;
          cmd.load_work = (status.fill == 6'd63);
        end
      end
      ST_PAD_MARK: begin
        cmd.ins_byte  = 1'b1;
        cmd.byte_sel  = BSEL_MARK;
        cmd.load_work = (status.fill == 6'd63);
      end
      ST_PAD_ZERO: begin
        cmd.byte_sel = BSEL_ZERO;
        if (status.fill != 6'd56) begin
          cmd.ins_byte  = 1'b1;
          cmd.load_work = (status.fill == 6'd63);
        end
      end
      ST_PAD_LEN: begin
        cmd.ins_byte  = 1'b1;
        cmd.byte_sel  = BSEL_LENGTH;
        cmd.load_work = (status.fill == 6'd63);
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update_chain = 1'b1;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.finish    = status.emit_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
